FILE: design/sha256_stream_hasher_top_defines.svh
// Assertion macros shared by the SHA-256 stream hasher modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sha256_pkg.sv
// Package for the SHA-256 stream hasher: payload structs, control struct,
// sequencer states, round constants, initial hash values and round functions.
// No dependencies.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef struct packed {
    logic push;
    logic start;
    logic init;
  } sha_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA_COMP,
    S_PAD,
    S_PAD_COMP,
    S_OUT
  } sha_state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_FIRST = 6'd56;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] sha_rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] sha_bsig0(input logic [31:0] x);
    return sha_rotr(x, 5'd2) ^ sha_rotr(x, 5'd13) ^ sha_rotr(x, 5'd22);
  endfunction

  function automatic logic [31:0] sha_bsig1(input logic [31:0] x);
    return sha_rotr(x, 5'd6) ^ sha_rotr(x, 5'd11) ^ sha_rotr(x, 5'd25);
  endfunction

  function automatic logic [31:0] sha_ssig0(input logic [31:0] x);
    return sha_rotr(x, 5'd7) ^ sha_rotr(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sha_ssig1(input logic [31:0] x);
    return sha_rotr(x, 5'd17) ^ sha_rotr(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

FILE: design/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: byte packing, padding sequencer
// and digest output register. Depends on sha256_pkg, sha256_core and the macros header.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one item per
// transfer: a message byte when has_byte is set, and end_of_message on the
// item that closes the message. The result channel (out_valid, out_stall,
// out_data) gives the eight digest words, word 0 first, last_word on word 7.
// Bytes are taken one per cycle while in_stall is low. A byte that completes
// a 64-byte block holds in_stall high while the shared round unit runs 64
// rounds and the final addition. An end_of_message item then appends the pad
// bytes one per cycle (up to 72), runs one compression, or two when the
// length field does not fit, and loads the digest words into the output
// register, one per cycle when out_stall is low. The digest words wait in the
// output register while out_stall is high; the input side takes the next
// message as soon as the last word is loaded. Reset is synchronous and active
// low and returns the hash state to the initial values with no bytes buffered.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_pkg::sha_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_pkg::sha_out_t out_data
);
  import sha256_pkg::*;

  sha_state_t     state_r, state_nxt;
  logic [5:0]     fill_r, fill_nxt;
  logic [23:0]    acc_r, acc_nxt;
  logic [63:0]    msg_bits_r, msg_bits_nxt;
  logic           mark_r, mark_nxt;
  logic           last_blk_r, last_blk_nxt;
  logic           end_pend_r, end_pend_nxt;
  logic [2:0]     oidx_r, oidx_nxt;
  logic           out_valid_r, out_valid_nxt;
  sha_out_t       out_data_r, out_data_nxt;

  logic           append_en;
  logic [7:0]     append_byte;
  logic [7:0]     len_byte;
  sha_ctl_t       ctl;
  logic           core_done;
  logic [7:0][31:0] hash_words;

  sha256_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .push_word  ({acc_r, append_byte}),
    .done       (core_done),
    .hash_words (hash_words)
  );

  assign len_byte = 8'(msg_bits_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    acc_nxt       = acc_r;
    msg_bits_nxt  = msg_bits_r;
    mark_nxt      = mark_r;
    last_blk_nxt  = last_blk_r;
    end_pend_nxt  = end_pend_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    append_en     = 1'b0;
    append_byte   = in_data.data_byte;
    ctl           = '0;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.has_byte) begin
            append_en    = 1'b1;
            msg_bits_nxt = msg_bits_r + 64'd8;
            if (fill_r == LAST_BYTE) begin
              state_nxt    = S_DATA_COMP;
              end_pend_nxt = in_data.end_of_message;
            end else if (in_data.end_of_message) begin
              state_nxt = S_PAD;
            end
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_DATA_COMP: begin
        if (core_done) begin
          state_nxt = end_pend_r ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        append_en = 1'b1;
        if (!mark_r) begin
          append_byte = PAD_MARK;
          if (fill_r < LEN_FIRST) begin
            last_blk_nxt = 1'b1;
          end
        end else if (last_blk_r && fill_r >= LEN_FIRST) begin
          append_byte = len_byte;
        end else begin
          append_byte = 8'h00;
        end
        mark_nxt = 1'b1;
        if (fill_r == LAST_BYTE) begin
          state_nxt = S_PAD_COMP;
        end
      end
      S_PAD_COMP: begin
        if (core_done) begin
          if (last_blk_r) begin
            state_nxt = S_OUT;
            oidx_nxt  = '0;
          end else begin
            last_blk_nxt = 1'b1;
            state_nxt    = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = hash_words[oidx_r];
          out_data_nxt.word_index  = oidx_r;
          out_data_nxt.last_word   = (oidx_r == LAST_WORD_IDX);
          oidx_nxt                 = oidx_r + 3'd1;
          if (oidx_r == LAST_WORD_IDX) begin
            ctl.init     = 1'b1;
            state_nxt    = S_IDLE;
            msg_bits_nxt = '0;
            mark_nxt     = 1'b0;
            last_blk_nxt = 1'b0;
            end_pend_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (append_en) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r[1:0] == 2'b11) begin
        ctl.push = 1'b1;
      end else begin
        acc_nxt = {acc_r[15:0], append_byte};
      end
      if (fill_r == LAST_BYTE) begin
        ctl.start = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      msg_bits_r  <= '0;
      mark_r      <= 1'b0;
      last_blk_r  <= 1'b0;
      end_pend_r  <= 1'b0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      msg_bits_r  <= msg_bits_nxt;
      mark_r      <= mark_nxt;
      last_blk_r  <= last_blk_nxt;
      end_pend_r  <= end_pend_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SHA_ASSERT_NOW(a_out_block_empty, state_r == S_OUT, fill_r == '0 && mark_r && last_blk_r,
                  "digest output with a partly filled block")
  `SHA_ASSERT_NOW(a_done_expected, core_done,
                  state_r == S_DATA_COMP || state_r == S_PAD_COMP,
                  "compression finished outside a wait state")
  `SHA_ASSERT_NEXT(a_final_reinit, state_r == S_OUT && ctl.init,
                   state_r == S_IDLE && msg_bits_r == '0 && out_valid_r && out_data_r.last_word,
                   "state not cleared after the last digest word")

endmodule

FILE: design/sha256_core.sv
// SHA-256 compression engine: 16-word schedule window, one round per cycle.
// Depends on sha256_pkg and the assertion macros header.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sha256_pkg::sha_ctl_t         ctl,
  input  logic [31:0]                  push_word,
  output logic                         done,
  output logic [7:0][31:0]             hash_words
);
  import sha256_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  rnd_r;
  logic        run_r;
  logic        fin_r;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_nxt;

  always_comb begin
    t1 = v_r[7] + sha_bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + SHA_K[rnd_r] + w_r[0];
    t2 = sha_bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_nxt = sha_ssig1(w_r[14]) + w_r[9] + sha_ssig0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (ctl.push || run_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= run_r ? w_nxt : push_word;
    end
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (run_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= SHA_IV[i];
      end
    end else begin
      fin_r <= 1'b0;
      if (ctl.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
      if (fin_r) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end else if (ctl.init) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= SHA_IV[i];
        end
      end
    end
  end

  assign done = fin_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_words[i] = h_r[i];
    end
  end

  `SHA_ASSERT_NOW(a_start_idle, ctl.start, !run_r && !fin_r, "start while compressing")
  `SHA_ASSERT_NOW(a_push_idle, ctl.push, !run_r, "word pushed during compression")
  `SHA_ASSERT_NEXT(a_last_round, run_r && rnd_r == LAST_ROUND, fin_r && !run_r,
                   "final addition did not follow the last round")
  `SHA_ASSERT_NOW(a_init_quiet, ctl.init, !run_r && !fin_r, "hash reinit during compression")

endmodule
